/* src/hhps_pkg.sv */
`timescale 1ns / 1ps

package hhps_pkg;

	// Widths of the result fields.
	localparam int PAGE_COUNT_W = 25;
	localparam int REMAINING_W  = 32;
	localparam int RESET_TIME_W = 33;

	// Defaults for the top-level parameters.
	localparam int PAGE_BITS_DEF   = 24;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Header names, matched at line start without regard to case.
	localparam int NAME_LINK_LEN = 4;
	localparam int NAME_REM_LEN  = 21;
	localparam int NAME_RST_LEN  = 17;
	localparam logic [8*NAME_LINK_LEN-1:0] NAME_LINK = "link";
	localparam logic [8*NAME_REM_LEN-1:0]  NAME_REM  = "x-ratelimit-remaining";
	localparam logic [8*NAME_RST_LEN-1:0]  NAME_RST  = "x-ratelimit-reset";

	// Patterns tracked inside the link line.
	localparam int PAGE_KEY_LEN = 5;
	localparam int REL_LEN      = 10;
	localparam logic [8*PAGE_KEY_LEN-1:0] PAT_PAGE = "page=";
	localparam logic [8*REL_LEN-1:0]      PAT_LAST = "rel=\"last\"";
	localparam logic [8*REL_LEN-1:0]      PAT_PREV = "rel=\"prev\"";

	// Indexes of the three header names.
	localparam logic [1:0] NAME_IDX_LINK = 2'd0;
	localparam logic [1:0] NAME_IDX_REM  = 2'd1;
	localparam logic [1:0] NAME_IDX_RST  = 2'd2;

	// Which value the current line feeds.
	typedef enum logic [1:0] {
		TGT_NONE = 2'd0,
		TGT_LINK = 2'd1,
		TGT_REM  = 2'd2,
		TGT_RST  = 2'd3
	} target_t;

	// One classified header byte as it sits in the queue.
	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] lower_byte;
		logic       is_digit;
		logic [3:0] digit;
		logic       is_newline;
		logic       is_blank;
		logic       is_colon;
		logic       prev_qual;
		logic       is_last;
	} byte_class_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	function automatic logic [4:0] name_len(input logic [1:0] idx);
		logic [4:0] len;
		unique case (idx)
			NAME_IDX_LINK: len = 5'(NAME_LINK_LEN);
			NAME_IDX_REM:  len = 5'(NAME_REM_LEN);
			NAME_IDX_RST:  len = 5'(NAME_RST_LEN);
			default:       len = 5'd0;
		endcase
		return len;
	endfunction

	// Character of a header name at a line position; zero past its end.
	function automatic logic [7:0] name_char(input logic [1:0] idx, input logic [4:0] pos);
		logic [7:0] c;
		c = 8'h00;
		unique case (idx)
			NAME_IDX_LINK: begin
				if (pos < 5'(NAME_LINK_LEN))
					c = NAME_LINK[8*(NAME_LINK_LEN-1-int'(pos)) +: 8];
			end
			NAME_IDX_REM: begin
				if (pos < 5'(NAME_REM_LEN))
					c = NAME_REM[8*(NAME_REM_LEN-1-int'(pos)) +: 8];
			end
			NAME_IDX_RST: begin
				if (pos < 5'(NAME_RST_LEN))
					c = NAME_RST[8*(NAME_RST_LEN-1-int'(pos)) +: 8];
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] page_char(input logic [2:0] pos);
		logic [7:0] c;
		c = 8'h00;
		if (pos < 3'(PAGE_KEY_LEN))
			c = PAT_PAGE[8*(PAGE_KEY_LEN-1-int'(pos)) +: 8];
		return c;
	endfunction

	function automatic logic [7:0] last_char(input logic [3:0] pos);
		logic [7:0] c;
		c = 8'h00;
		if (pos < 4'(REL_LEN))
			c = PAT_LAST[8*(REL_LEN-1-int'(pos)) +: 8];
		return c;
	endfunction

	function automatic logic [7:0] prev_char(input logic [3:0] pos);
		logic [7:0] c;
		c = 8'h00;
		if (pos < 4'(REL_LEN))
			c = PAT_PREV[8*(REL_LEN-1-int'(pos)) +: 8];
		return c;
	endfunction

endpackage

/* src/hhps_front.sv */
`timescale 1ns / 1ps

module hhps_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                data_byte,
	input  logic                      end_of_block,
	input  hhps_pkg::queue_stat_t     q_stat,
	output logic                      push,
	output hhps_pkg::byte_class_t     entry
);
	import hhps_pkg::*;

	// Set when the byte before this one was a '?' or an '&'.
	logic prev_qual_q;

	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;

	always_comb begin
		entry.data_byte  = data_byte;
		entry.lower_byte = (data_byte >= "A" && data_byte <= "Z") ?
			data_byte + 8'd32 : data_byte;
		entry.is_digit   = (data_byte >= "0" && data_byte <= "9");
		entry.digit      = 4'(data_byte - "0");
		entry.is_newline = (data_byte == "\n");
		entry.is_blank   = (data_byte == " " || data_byte == "\t");
		entry.is_colon   = (data_byte == ":");
		entry.prev_qual  = prev_qual_q;
		entry.is_last    = end_of_block;
	end

	// The previous byte starts over as zero with every new block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_qual_q <= 1'b0;
		end else if (push) begin
			prev_qual_q <= !end_of_block && (data_byte == "?" || data_byte == "&");
		end
	end

endmodule

/* src/hhps_fifo.sv */
`timescale 1ns / 1ps

module hhps_fifo #(
	parameter int DEPTH = hhps_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  hhps_pkg::byte_class_t push_data,
	input  logic                  pop,
	output hhps_pkg::byte_class_t head,
	output hhps_pkg::queue_stat_t q_stat
);
	import hhps_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	byte_class_t         slot_q [DEPTH];
	logic [PW-1:0]       wr_ptr_q;
	logic [PW-1:0]       rd_ptr_q;
	logic [CW-1:0]       count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] ptr);
		return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
	endfunction

	assign head         = slot_q[rd_ptr_q];
	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/hhps_back.sv */
`timescale 1ns / 1ps

module hhps_back #(
	parameter int PAGE_BITS = hhps_pkg::PAGE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  hhps_pkg::queue_stat_t                 q_stat,
	input  hhps_pkg::byte_class_t                 head,
	output logic                                  pop,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [hhps_pkg::PAGE_COUNT_W-1:0]     page_count,
	output logic signed [hhps_pkg::REMAINING_W-1:0] rate_remaining,
	output logic signed [hhps_pkg::RESET_TIME_W-1:0] rate_reset_time
);
	import hhps_pkg::*;

	// Scanner state.
	logic [4:0]           line_pos_q,  line_pos_d;
	logic [2:0]           cand_q,      cand_d;
	target_t              target_q,    target_d;
	logic                 skip_q,      skip_d;
	logic [2:0]           seen_q,      seen_d;
	logic [30:0]          rem_q,       rem_d;
	logic [31:0]          rst_q,       rst_d;
	logic [PAGE_BITS-1:0] cur_page_q,  cur_page_d;
	logic [2:0]           pk_q,        pk_d;
	logic [3:0]           rel_q,       rel_d;
	logic [3:0]           prv_q,       prv_d;
	logic                 key_ok_q,    key_ok_d;
	logic                 reading_q,   reading_d;
	logic                 pvalid_q,    pvalid_d;
	logic                 last_fnd_q,  last_fnd_d;
	logic                 prev_fnd_q,  prev_fnd_d;
	logic [PAGE_BITS-1:0] last_page_q, last_page_d;
	logic [PAGE_BITS:0]   prev_page_q, prev_page_d;
	logic                 closed_q,    closed_d;

	// Result register.
	logic                     out_valid_q;
	logic [PAGE_COUNT_W-1:0]  page_count_q,  page_count_d;
	logic [REMAINING_W-1:0]   remaining_q,   remaining_d;
	logic [RESET_TIME_W-1:0]  reset_time_q,  reset_time_d;

	// Saturating decimal accumulators.
	logic [PAGE_BITS+3:0] page_acc;
	logic [PAGE_BITS-1:0] page_sat;
	logic [34:0]          rem_acc;
	logic [30:0]          rem_sat;
	logic [35:0]          rst_acc;
	logic [31:0]          rst_sat;

	logic [2:0] hit;
	logic       consume;
	logic [2:0] pk_new;
	logic [7:0] b;

	assign b = head.data_byte;

	// A last byte waits while the previous result is still held.
	assign pop = !q_stat.empty && (!head.is_last || !out_valid_q || !out_stall);

	always_comb begin
		page_acc = ({4'b0, cur_page_q} << 3) + ({4'b0, cur_page_q} << 1)
			+ (PAGE_BITS+4)'(head.digit);
		page_sat = (|page_acc[PAGE_BITS+3:PAGE_BITS]) ? '1 : page_acc[PAGE_BITS-1:0];
		rem_acc  = ({4'b0, rem_q} << 3) + ({4'b0, rem_q} << 1) + 35'(head.digit);
		rem_sat  = (|rem_acc[34:31]) ? '1 : rem_acc[30:0];
		rst_acc  = ({4'b0, rst_q} << 3) + ({4'b0, rst_q} << 1) + 36'(head.digit);
		rst_sat  = (|rst_acc[35:32]) ? '1 : rst_acc[31:0];
	end

	always_comb begin
		line_pos_d  = line_pos_q;
		cand_d      = cand_q;
		target_d    = target_q;
		skip_d      = skip_q;
		seen_d      = seen_q;
		rem_d       = rem_q;
		rst_d       = rst_q;
		cur_page_d  = cur_page_q;
		pk_d        = pk_q;
		rel_d       = rel_q;
		prv_d       = prv_q;
		key_ok_d    = key_ok_q;
		reading_d   = reading_q;
		pvalid_d    = pvalid_q;
		last_fnd_d  = last_fnd_q;
		prev_fnd_d  = prev_fnd_q;
		last_page_d = last_page_q;
		prev_page_d = prev_page_q;
		closed_d    = closed_q;
		hit         = '0;
		consume     = 1'b1;
		pk_new      = '0;

		if (target_q == TGT_NONE) begin
			if (!head.is_newline) begin
				for (int i = 0; i < 3; i++)
					hit[i] = cand_q[i] && line_pos_q == name_len(2'(i)) && head.is_colon;
				if (|hit) begin
					seen_d = seen_q | hit;
					skip_d = 1'b1;
					cand_d = '0;
					if (hit[NAME_IDX_LINK])
						target_d = TGT_LINK;
					else if (hit[NAME_IDX_REM])
						target_d = TGT_REM;
					else
						target_d = TGT_RST;
				end else begin
					for (int i = 0; i < 3; i++) begin
						if (cand_q[i]) begin
							if (line_pos_q < name_len(2'(i))) begin
								if (head.lower_byte != name_char(2'(i), line_pos_q))
									cand_d[i] = 1'b0;
							end else begin
								cand_d[i] = 1'b0;
							end
						end
					end
				end
			end
		end else begin
			if (skip_q) begin
				if (head.is_blank)
					consume = 1'b0;
				else
					skip_d = 1'b0;
			end
			if (consume) begin
				if (target_q == TGT_LINK) begin
					if (head.is_newline) begin
						closed_d = 1'b1;
					end else begin
						// A rel pattern takes the page seen before it on the line.
						if (rel_q == 4'(REL_LEN) && pvalid_q && !last_fnd_q) begin
							last_fnd_d  = 1'b1;
							last_page_d = cur_page_q;
						end
						if (prv_q == 4'(REL_LEN) && pvalid_q) begin
							prev_fnd_d  = 1'b1;
							prev_page_d = {1'b0, cur_page_q} + (PAGE_BITS+1)'(1);
						end
						if (reading_q) begin
							if (head.is_digit)
								cur_page_d = page_sat;
							else
								reading_d = 1'b0;
						end
						if (pk_q < 3'(PAGE_KEY_LEN) && b == page_char(pk_q))
							pk_new = pk_q + 3'd1;
						else
							pk_new = (b == page_char(3'd0)) ? 3'd1 : 3'd0;
						if (pk_new == 3'd1)
							key_ok_d = head.prev_qual;
						if (pk_new == 3'(PAGE_KEY_LEN)) begin
							if (key_ok_q) begin
								pvalid_d   = 1'b1;
								reading_d  = 1'b1;
								cur_page_d = '0;
							end
							pk_d = '0;
						end else begin
							pk_d = pk_new;
						end
						if (rel_q < 4'(REL_LEN) && b == last_char(rel_q))
							rel_d = rel_q + 4'd1;
						else
							rel_d = (b == last_char(4'd0)) ? 4'd1 : 4'd0;
						if (prv_q < 4'(REL_LEN) && b == prev_char(prv_q))
							prv_d = prv_q + 4'd1;
						else
							prv_d = (b == prev_char(4'd0)) ? 4'd1 : 4'd0;
					end
				end else if (head.is_digit) begin
					if (target_q == TGT_REM)
						rem_d = rem_sat;
					else
						rst_d = rst_sat;
				end else begin
					target_d = TGT_NONE;
				end
			end
		end

		if (head.is_newline) begin
			line_pos_d = '0;
			cand_d     = ~seen_q;
			target_d   = TGT_NONE;
			skip_d     = 1'b0;
		end else if (line_pos_q != 5'd31) begin
			line_pos_d = line_pos_q + 5'd1;
		end

		page_count_d = PAGE_COUNT_W'(1);
		if (seen_d[NAME_IDX_LINK] && closed_d) begin
			if (last_fnd_d)
				page_count_d = PAGE_COUNT_W'(last_page_d);
			else if (prev_fnd_d)
				page_count_d = PAGE_COUNT_W'(prev_page_d);
		end
		remaining_d  = seen_d[NAME_IDX_REM] ? {1'b0, rem_d} : '1;
		reset_time_d = seen_d[NAME_IDX_RST] ? {1'b0, rst_d} : '1;

		// The block's last byte leaves the scanner as after reset.
		if (head.is_last) begin
			line_pos_d  = '0;
			cand_d      = '1;
			target_d    = TGT_NONE;
			skip_d      = 1'b0;
			seen_d      = '0;
			rem_d       = '0;
			rst_d       = '0;
			cur_page_d  = '0;
			pk_d        = '0;
			rel_d       = '0;
			prv_d       = '0;
			key_ok_d    = 1'b0;
			reading_d   = 1'b0;
			pvalid_d    = 1'b0;
			last_fnd_d  = 1'b0;
			prev_fnd_d  = 1'b0;
			last_page_d = '0;
			prev_page_d = '0;
			closed_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pos_q  <= '0;
			cand_q      <= '1;
			target_q    <= TGT_NONE;
			skip_q      <= 1'b0;
			seen_q      <= '0;
			rem_q       <= '0;
			rst_q       <= '0;
			cur_page_q  <= '0;
			pk_q        <= '0;
			rel_q       <= '0;
			prv_q       <= '0;
			key_ok_q    <= 1'b0;
			reading_q   <= 1'b0;
			pvalid_q    <= 1'b0;
			last_fnd_q  <= 1'b0;
			prev_fnd_q  <= 1'b0;
			last_page_q <= '0;
			prev_page_q <= '0;
			closed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				line_pos_q  <= line_pos_d;
				cand_q      <= cand_d;
				target_q    <= target_d;
				skip_q      <= skip_d;
				seen_q      <= seen_d;
				rem_q       <= rem_d;
				rst_q       <= rst_d;
				cur_page_q  <= cur_page_d;
				pk_q        <= pk_d;
				rel_q       <= rel_d;
				prv_q       <= prv_d;
				key_ok_q    <= key_ok_d;
				reading_q   <= reading_d;
				pvalid_q    <= pvalid_d;
				last_fnd_q  <= last_fnd_d;
				prev_fnd_q  <= prev_fnd_d;
				last_page_q <= last_page_d;
				prev_page_q <= prev_page_d;
				closed_q    <= closed_d;
			end
			if (pop && head.is_last)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.is_last) begin
			page_count_q <= page_count_d;
			remaining_q  <= remaining_d;
			reset_time_q <= reset_time_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign page_count      = page_count_q;
	assign rate_remaining  = signed'(remaining_q);
	assign rate_reset_time = signed'(reset_time_q);

endmodule

/* src/http_header_pagination_scanner.sv */
// Result path: a block's final byte goes into the queue and is then popped into the output
// register, which puts its result beat on the ports; that pop waits while an older beat is held.
// Throughput: one header byte per cycle unless a final byte waits on a held beat; the back end
// updates all matchers at once for each byte.
// Reset: arst_n clears the queue, the scanner state and the output valid at once; no clearing pass.
`timescale 1ns / 1ps

module http_header_pagination_scanner #(
	parameter int PAGE_BITS   = hhps_pkg::PAGE_BITS_DEF,
	parameter int QUEUE_DEPTH = hhps_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [7:0]                               data_byte,
	input  logic                                     end_of_block,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [hhps_pkg::PAGE_COUNT_W-1:0]        page_count,
	output logic signed [hhps_pkg::REMAINING_W-1:0]  rate_remaining,
	output logic signed [hhps_pkg::RESET_TIME_W-1:0] rate_reset_time
);
	import hhps_pkg::*;

	// The front end classifies each byte (case folding, digit value, separators and
	// whether the byte before it opens a query parameter) and writes it into a small
	// queue. The back end pops one classified byte per cycle and runs the name
	// matchers, value accumulators and link-line pattern trackers. Only the final byte
	// of a block has to wait for the output register; ordinary bytes keep flowing even
	// while a result beat is held by a stalled receiver.

	queue_stat_t q_stat;
	byte_class_t push_entry;
	byte_class_t head;
	logic        push;
	logic        pop;

	hhps_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.end_of_block (end_of_block),
		.q_stat       (q_stat),
		.push         (push),
		.entry        (push_entry)
	);

	hhps_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	hhps_back #(
		.PAGE_BITS (PAGE_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_stat          (q_stat),
		.head            (head),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.page_count      (page_count),
		.rate_remaining  (rate_remaining),
		.rate_reset_time (rate_reset_time)
	);

	// The back end never reads an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// A final byte is not consumed while a result beat is still held.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.is_last) |-> !(out_valid && out_stall))
		else $error("result overwritten while stalled");

	// A result beat appears only after a final byte left the queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pop && head.is_last))
		else $error("result without final byte");

	// Nothing enters the queue while it is full.
	assert property (@(posedge clk) disable iff (!arst_n) q_stat.full |-> !push)
		else $error("push into full queue");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
	import hhps_pkg::*;

	// Stall and gap rate of both sides, in percent of cycles.
	localparam int STALL_PCT = 22;
	// Cycles without any accepted beat after which the run is declared hung.
	localparam int WATCHDOG_LIMIT = 3000;
	// Length of the one long hold-off on the result side.
	localparam int HOLD_OFF_CYCLES = 160;
	// The random part stops once both of these are reached.
	localparam int TARGET_BYTES = 1950;
	localparam int MIN_BLOCKS = 40;
	// Cycles waited after every expected summary is checked, so that a stray result beat is caught.
	localparam int DRAIN_CYCLES = 10;

	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_COLON = ":";
	localparam logic [7:0] CH_QMARK = "?";
	localparam logic [7:0] CH_AMP = "&";
	localparam logic [7:0] CH_PLUS = "+";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_ZERO = "0";
	localparam logic [7:0] CH_NINE = "9";
	localparam logic [7:0] CH_UP_A = "A";
	localparam logic [7:0] CH_UP_Z = "Z";
	localparam logic [7:0] CH_LO_A = "a";
	localparam logic [7:0] CH_LO_Z = "z";

	localparam longint unsigned REMAINING_CAP = 64'h7FFF_FFFF;
	localparam longint unsigned RESET_CAP = 64'hFFFF_FFFF;
	localparam longint unsigned PAGE_CAP = (64'd1 << PAGE_BITS_DEF) - 64'd1;
	localparam int LINE_POS_CAP = 31;

	// The scoreboard carries its own copy of the scanner state. Every accepted
	// beat is run through it, and the final beat of a block leaves one expected
	// summary behind, which the next result beat is compared against.
	class pagination_scoreboard;
		typedef struct {
			logic [PAGE_COUNT_W-1:0] pages;
			logic [REMAINING_W-1:0]  remaining;
			logic [RESET_TIME_W-1:0] reset_time;
		} summary_t;

		summary_t expected_summaries[$];
		int unsigned mismatches;
		int unsigned summaries_checked;
		int unsigned from_last, from_prev, with_remaining, with_reset;

		string header_names[3];
		string page_key, last_key, prev_key;

		int unsigned line_pos, page_prog, last_prog, prev_prog;
		logic [2:0] candidates, seen;
		target_t target;
		bit skipping, link_closed, key_ok, page_reading, page_valid, last_found, prev_found;
		longint unsigned remaining_acc, reset_acc, page_acc, last_page, prev_page;
		logic [7:0] prior_byte;

		function new();
			header_names = '{"link", "x-ratelimit-remaining", "x-ratelimit-reset"};
			page_key = "page=";
			last_key = "rel=\"last\"";
			prev_key = "rel=\"prev\"";
			clear_scan();
		endfunction

		function void clear_scan();
			line_pos = 0;
			candidates = 3'b111;
			target = TGT_NONE;
			skipping = 1'b0;
			seen = 3'b000;
			remaining_acc = 0;
			reset_acc = 0;
			page_acc = 0;
			page_prog = 0;
			last_prog = 0;
			prev_prog = 0;
			prior_byte = 8'h00;
			last_page = 0;
			prev_page = 0;
			link_closed = 1'b0;
			key_ok = 1'b0;
			page_reading = 1'b0;
			page_valid = 1'b0;
			last_found = 1'b0;
			prev_found = 1'b0;
		endfunction

		function bit is_digit(logic [7:0] b);
			return b >= CH_ZERO && b <= CH_NINE;
		endfunction

		function longint unsigned saturate(longint unsigned acc, logic [7:0] b,
				longint unsigned cap);
			acc = acc * 10 + longint'(b - CH_ZERO);
			return (acc > cap) ? cap : acc;
		endfunction

		// Progress through a fixed pattern; a mismatch may restart it at once.
		function int unsigned advance(int unsigned prog, logic [7:0] b, string pat);
			if (prog < pat.len() && b == pat[prog])
				return prog + 1;
			return (b == pat[0]) ? 1 : 0;
		endfunction

		function void scan_byte(logic [7:0] b, logic eob);
			logic [7:0] lb;
			bit consume, hit;
			longint unsigned pc;
			summary_t s;
			lb = (b >= CH_UP_A && b <= CH_UP_Z) ? b + 8'd32 : b;
			if (target == TGT_NONE) begin
				if (b != CH_NL) begin
					// Name matching: each still-live name drops out on a wrong
					// letter, and the first one followed by a colon wins the line.
					hit = 1'b0;
					for (int i = 0; i < 3; i++) begin
						if (!hit && candidates[i]) begin
							if (line_pos < header_names[i].len()) begin
								if (lb != header_names[i][line_pos])
									candidates[i] = 1'b0;
							end else if (line_pos == header_names[i].len() && b == CH_COLON) begin
								seen[i] = 1'b1;
								target = target_t'(i + 1);
								skipping = 1'b1;
								candidates = 3'b000;
								hit = 1'b1;
							end else begin
								candidates[i] = 1'b0;
							end
						end
					end
				end
			end else begin
				consume = 1'b1;
				if (skipping) begin
					if (b == CH_SP || b == CH_TAB)
						consume = 1'b0;
					else
						skipping = 1'b0;
				end
				if (consume) begin
					if (target == TGT_LINK) begin
						if (b == CH_NL) begin
							link_closed = 1'b1;
						end else begin
							// A rel pattern takes effect one byte after it completes.
							if (last_prog == last_key.len() && page_valid && !last_found) begin
								last_found = 1'b1;
								last_page = page_acc;
							end
							if (prev_prog == prev_key.len() && page_valid) begin
								prev_found = 1'b1;
								prev_page = page_acc + 1;
							end
							if (page_reading) begin
								if (is_digit(b))
									page_acc = saturate(page_acc, b, PAGE_CAP);
								else
									page_reading = 1'b0;
							end
							page_prog = advance(page_prog, b, page_key);
							if (page_prog == 1)
								key_ok = (prior_byte == CH_QMARK || prior_byte == CH_AMP);
							if (page_prog == page_key.len()) begin
								if (key_ok) begin
									page_valid = 1'b1;
									page_reading = 1'b1;
									page_acc = 0;
								end
								page_prog = 0;
							end
							last_prog = advance(last_prog, b, last_key);
							prev_prog = advance(prev_prog, b, prev_key);
						end
					end else if (is_digit(b)) begin
						if (target == TGT_REM)
							remaining_acc = saturate(remaining_acc, b, REMAINING_CAP);
						else
							reset_acc = saturate(reset_acc, b, RESET_CAP);
					end else begin
						target = TGT_NONE;
					end
				end
			end

			if (b == CH_NL) begin
				line_pos = 0;
				candidates = ~seen;
				target = TGT_NONE;
				skipping = 1'b0;
			end else if (line_pos < LINE_POS_CAP) begin
				line_pos++;
			end
			prior_byte = b;

			if (eob) begin
				pc = 1;
				if (seen[NAME_IDX_LINK] && link_closed) begin
					if (last_found) begin
						pc = last_page;
						from_last++;
					end else if (prev_found) begin
						pc = prev_page;
						from_prev++;
					end
				end
				s.pages = pc[PAGE_COUNT_W-1:0];
				s.remaining = seen[NAME_IDX_REM] ? remaining_acc[REMAINING_W-1:0] : '1;
				s.reset_time = seen[NAME_IDX_RST] ? reset_acc[RESET_TIME_W-1:0] : '1;
				with_remaining += seen[NAME_IDX_REM];
				with_reset += seen[NAME_IDX_RST];
				expected_summaries.push_back(s);
				clear_scan();
			end
		endfunction

		function void check_result(logic [PAGE_COUNT_W-1:0] pages,
				logic [REMAINING_W-1:0] remaining, logic [RESET_TIME_W-1:0] reset_time);
			summary_t want;
			if (expected_summaries.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: summary with no block behind it: pages %0d, remaining %0d, reset %0d",
						$time, pages, $signed(remaining), $signed(reset_time));
				return;
			end
			want = expected_summaries.pop_front();
			summaries_checked++;
			if (pages !== want.pages || remaining !== want.remaining
					|| reset_time !== want.reset_time) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: summary %0d differs", $time, summaries_checked);
					$display("  pages     expected %0d, got %0d", want.pages, pages);
					$display("  remaining expected %0d, got %0d",
						$signed(want.remaining), $signed(remaining));
					$display("  reset     expected %0d, got %0d",
						$signed(want.reset_time), $signed(reset_time));
				end
			end
		endfunction
	endclass

	// Every input of the block starts at a known value.
	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] data_byte = 8'h00;
	logic end_of_block = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PAGE_COUNT_W-1:0] page_count;
	logic signed [REMAINING_W-1:0] rate_remaining;
	logic signed [RESET_TIME_W-1:0] rate_reset_time;

	pagination_scoreboard board;
	logic [7:0] block_bytes[$];
	int unsigned bytes_sent, blocks_sent, quiet_cycles;
	int hold_left;
	// Set by the stimulus to ask for the long hold-off; the result side clears it.
	bit hold_request;
	// While set, neither side inserts gaps or stalls.
	bit steady_phase;

	http_header_pagination_scanner dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.end_of_block(end_of_block),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.page_count(page_count),
		.rate_remaining(rate_remaining),
		.rate_reset_time(rate_reset_time)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Block builders. Each appends bytes to the block under construction.
	function void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			block_bytes.push_back(s[i]);
	endfunction

	// Header names go out in mixed case, since matching ignores case.
	function void put_name(string s);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (c >= CH_LO_A && c <= CH_LO_Z && $urandom_range(0, 1) == 1)
				c = c - 8'd32;
			block_bytes.push_back(c);
		end
	endfunction

	function void put_blanks();
		repeat ($urandom_range(0, 3))
			block_bytes.push_back(($urandom_range(0, 2) == 0) ? CH_TAB : CH_SP);
	endfunction

	// Mostly short numbers; sometimes long enough to saturate any accumulator,
	// and sometimes no digits at all.
	function void put_number();
		int n;
		case ($urandom_range(0, 9))
			0: n = 0;
			1, 2: n = $urandom_range(9, 12);
			default: n = $urandom_range(1, 5);
		endcase
		repeat (n)
			block_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	// A bare newline leaves a rel pattern at the very end of the line, where it
	// does not count; a carriage return first gives it the byte it needs.
	function void put_eol();
		if ($urandom_range(0, 3) == 0)
			block_bytes.push_back(CH_CR);
		block_bytes.push_back(CH_NL);
	endfunction

	function void put_rate_line(string name);
		put_name(name);
		block_bytes.push_back(CH_COLON);
		put_blanks();
		case ($urandom_range(0, 9))
			0: begin
				block_bytes.push_back(CH_MINUS);
				put_number();
			end
			1: begin
				block_bytes.push_back(CH_PLUS);
				put_number();
			end
			2: ;
			default: put_number();
		endcase
		if ($urandom_range(0, 3) == 0)
			put_text(", 7");
		put_eol();
	endfunction

	// A link line is a list of targets. The byte before page= decides whether
	// the page counts, and segments without page= leave rel patterns orphaned.
	function void put_link_line();
		put_name("link");
		block_bytes.push_back(CH_COLON);
		put_blanks();
		repeat ($urandom_range(1, 3)) begin
			put_text("<h/");
			if ($urandom_range(0, 6) != 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: block_bytes.push_back(CH_QMARK);
					4, 5, 6: block_bytes.push_back(CH_AMP);
					7: put_text("x");
					8: put_text("?pa");
					default: ;
				endcase
				put_text("page=");
				put_number();
			end
			put_text(">; ");
			case ($urandom_range(0, 5))
				0, 1: put_text("rel=\"last\"");
				2, 3: put_text("rel=\"prev\"");
				4: put_text("rel=\"next\"");
				default: put_text("rel=\"la");
			endcase
			if ($urandom_range(0, 2) != 0)
				put_text(", ");
		end
		put_eol();
	endfunction

	// Near misses of the three names, unrelated headers and raw noise.
	function void put_other_line();
		case ($urandom_range(0, 7))
			0: put_text("Content-Type: text/html");
			1: put_text("link :?page=4");
			2: put_text("lin:?page=4");
			3: put_text("linkage:?page=9");
			4: put_text("x-ratelimit-rese: 5");
			5: put_text("x-ratelimit-remaining-x: 6");
			6: put_text("X-RateLimit-Limit: 60");
			default: begin
				repeat ($urandom_range(20, 45))
					block_bytes.push_back(8'($urandom_range(0, 255)));
			end
		endcase
		put_eol();
	endfunction

	function void build_block();
		block_bytes.delete();
		if ($urandom_range(0, 4) == 0)
			put_text("HTTP/1.1 200 OK\n");
		repeat ($urandom_range(1, 3)) begin
			case ($urandom_range(0, 9))
				0, 1, 2: put_link_line();
				3, 4: put_rate_line("x-ratelimit-remaining");
				5, 6: put_rate_line("x-ratelimit-reset");
				7, 8: put_other_line();
				default: begin
					repeat ($urandom_range(0, 5))
						block_bytes.push_back(8'($urandom_range(0, 255)));
					block_bytes.push_back(CH_NL);
				end
			endcase
		end
		// Now and then the block ends inside its last line.
		if (block_bytes.size() > 1 && $urandom_range(0, 4) == 0)
			void'(block_bytes.pop_back());
	endfunction

	// One beat on the input side. Gaps are decided before valid rises, so valid
	// never looks at the stall, and the payload holds until the beat is taken.
	task automatic send_beat(input logic [7:0] b, input logic eob);
		while (!steady_phase && $urandom_range(0, 99) < STALL_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_block <= eob;
		do
			@(posedge clk);
		while (in_stall);
		board.scan_byte(b, eob);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_block();
		for (int i = 0; i < block_bytes.size(); i++)
			send_beat(block_bytes[i], i == block_bytes.size() - 1);
		blocks_sent++;
	endtask

	// Result side: random stalls at the falling edge, plus the one long hold-off,
	// which this process counts down itself.
	initial begin
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !steady_phase && ($urandom_range(0, 99) < STALL_PCT);
			end
		end
	end

	// Result beats are taken at the rising edge, where the stall seen is the one
	// driven at the falling edge before it.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(page_count, rate_remaining, rate_reset_time);
	end

	// Hang detection: any beat on either side restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles, %0d summaries still owed",
				$time, WATCHDOG_LIMIT, board.expected_summaries.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		board = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed blocks: a lone zero byte, a lone all-ones byte, a reset
		// header whose value starts with a sign, and a lone newline.
		block_bytes = '{8'h00};
		send_block();
		block_bytes = '{8'hFF};
		send_block();
		block_bytes.delete();
		put_text("x-ratelimit-reset:-4");
		send_block();
		block_bytes = '{CH_NL};
		send_block();

		while (bytes_sent < TARGET_BYTES || blocks_sent < MIN_BLOCKS) begin
			steady_phase = (blocks_sent >= 15 && blocks_sent < 25);
			if (blocks_sent == 30) begin
				// Pile up short blocks behind a stalled result port until the
				// input backs up too.
				hold_request = 1'b1;
				repeat (12) begin
					block_bytes.delete();
					repeat ($urandom_range(1, 2))
						block_bytes.push_back(8'($urandom_range(0, 255)));
					send_block();
				end
			end
			build_block();
			send_block();
		end
		in_valid <= 1'b0;

		while (board.expected_summaries.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);

		$display("%0d header blocks in %0d bytes, %0d summaries checked, %0d mismatches",
			blocks_sent, bytes_sent, board.summaries_checked, board.mismatches);
		$display("page count from rel=last %0d, from rel=prev %0d; remaining seen %0d, reset seen %0d",
			board.from_last, board.from_prev, board.with_remaining, board.with_reset);
		if (board.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

/* http_header_pagination_scanner.f */
src/hhps_pkg.sv
src/hhps_front.sv
src/hhps_fifo.sv
src/hhps_back.sv
src/http_header_pagination_scanner.sv
sim/tb.sv
